### rtl/core/u16u8_pkg.sv
// Shared types, constants and the UTF-8 encoding function of the transcoder.
`default_nettype none

package u16u8_pkg;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE       = 21'h10000;
   localparam logic [20:0] ONE_BYTE_LIMIT  = 21'h00080;
   localparam logic [20:0] TWO_BYTE_LIMIT  = 21'h00800;
   localparam logic [20:0] THREE_BYTE_LIMIT = 21'h10000;
   localparam logic [7:0]  CONT_PREFIX     = 8'h80;
   localparam logic [7:0]  LEAD2_PREFIX    = 8'hC0;
   localparam logic [7:0]  LEAD3_PREFIX    = 8'hE0;
   localparam logic [7:0]  LEAD4_PREFIX    = 8'hF0;
   localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;
   localparam int          MAX_JOB_BYTES   = 6;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // Bytes of one code point, first byte in element 0
   typedef struct packed {
      logic [2:0]      byte_count;
      logic [3:0][7:0] bytes;
   } enc_type;

   // All bytes one input item produces
   typedef struct packed {
      logic [2:0]                    byte_count;
      logic [MAX_JOB_BYTES-1:0][7:0] bytes;
   } job_type;

   function automatic enc_type encode_cp(input logic [20:0] cp);
      enc_type e;
      e = '0;
      if (cp < ONE_BYTE_LIMIT) begin
         e.byte_count = 3'd1;
         e.bytes[0]   = cp[7:0];
      end else if (cp < TWO_BYTE_LIMIT) begin
         e.byte_count = 3'd2;
         e.bytes[0]   = LEAD2_PREFIX | {3'b000, cp[10:6]};
         e.bytes[1]   = CONT_PREFIX | {2'b00, cp[5:0]};
      end else if (cp < THREE_BYTE_LIMIT) begin
         e.byte_count = 3'd3;
         e.bytes[0]   = LEAD3_PREFIX | {4'b0000, cp[15:12]};
         e.bytes[1]   = CONT_PREFIX | {2'b00, cp[11:6]};
         e.bytes[2]   = CONT_PREFIX | {2'b00, cp[5:0]};
      end else begin
         e.byte_count = 3'd4;
         e.bytes[0]   = LEAD4_PREFIX | {5'b00000, cp[20:18]};
         e.bytes[1]   = CONT_PREFIX | {2'b00, cp[17:12]};
         e.bytes[2]   = CONT_PREFIX | {2'b00, cp[11:6]};
         e.bytes[3]   = CONT_PREFIX | {2'b00, cp[5:0]};
      end
      return e;
   endfunction

endpackage

`default_nettype wire

### rtl/core/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and builds the byte job.
`default_nettype none

module u16u8_front
   import u16u8_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push,
   output job_type      push_job
);

   logic       pend_ff, pend_in;
   logic [9:0] pend_bits_ff, pend_bits_in;
   logic       accept;
   logic       is_high, is_low, emit_cur;
   logic [20:0] pair_cp;
   enc_type    enc_cur, enc_pend, enc_pair;
   job_type    job;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign is_high = (req_data.code_unit >= HIGH_SURR_FIRST) &&
                    (req_data.code_unit <= HIGH_SURR_LAST);
   assign is_low  = (req_data.code_unit >= LOW_SURR_FIRST) &&
                    (req_data.code_unit <= LOW_SURR_LAST);
   assign emit_cur = !(is_high && !req_data.end_of_string);

   assign pair_cp  = SUPP_BASE + {1'b0, pend_bits_ff, req_data.code_unit[9:0]};
   assign enc_cur  = encode_cp({5'b00000, req_data.code_unit});
   assign enc_pend = encode_cp({5'b00000, HIGH_SURR_TAG, pend_bits_ff});
   assign enc_pair = encode_cp(pair_cp);

   always_comb begin
      job = '0;
      if (pend_ff && is_low) begin
         job.byte_count  = enc_pair.byte_count;
         job.bytes[3:0]  = enc_pair.bytes;
      end else if (pend_ff) begin
         // flush the waiting surrogate first, then the current unit behind it unless that unit is held
         job.bytes[2:0] = enc_pend.bytes[2:0];
         job.byte_count = enc_pend.byte_count;
         if (emit_cur) begin
            job.bytes[5:3] = enc_cur.bytes[2:0];
            job.byte_count = enc_pend.byte_count + enc_cur.byte_count;
         end
      end else if (emit_cur) begin
         job.bytes[3:0] = enc_cur.bytes;
         job.byte_count = enc_cur.byte_count;
      end
   end

   assign push     = accept && (job.byte_count != 3'd0);
   assign push_job = job;

   always_comb begin
      pend_in      = pend_ff;
      pend_bits_in = pend_bits_ff;
      if (accept) begin
         if (!(pend_ff && is_low) && is_high && !req_data.end_of_string) begin
            pend_in      = 1'b1;
            pend_bits_in = req_data.code_unit[9:0];
         end else begin
            pend_in      = 1'b0;
            pend_bits_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         pend_bits_ff <= '0;
      end else begin
         pend_ff      <= pend_in;
         pend_bits_ff <= pend_bits_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_eos_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_string) |=> !pend_ff)
      else $error("surrogate held after last unit of string");
`endif

endmodule

`default_nettype wire

### rtl/core/u16u8_queue.sv
// Short job queue between the front end and the byte serialiser.
`default_nettype none

module u16u8_queue
   import u16u8_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("job pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(DEPTH)) && ((count_ff == '0) || (head_job.byte_count != 3'd0)))
      else $error("queue count out of range or empty job stored");
`endif

endmodule

`default_nettype wire

### rtl/core/u16u8_back.sv
// Back end: sends the bytes of the head job one per cycle while rsp_stall is low, through an output register.
`default_nettype none

module u16u8_back
   import u16u8_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [2:0] idx_ff, idx_in;
   logic       load, is_last;
   logic [7:0] cur_byte;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign is_last = (idx_ff == head_job.byte_count - 3'd1);
   assign pop     = load && head_valid && is_last;

   always_comb begin
      case (idx_ff)
         3'd0:    cur_byte = head_job.bytes[0];
         3'd1:    cur_byte = head_job.bytes[1];
         3'd2:    cur_byte = head_job.bytes[2];
         3'd3:    cur_byte = head_job.bytes[3];
         3'd4:    cur_byte = head_job.bytes[4];
         3'd5:    cur_byte = head_job.bytes[5];
         default: cur_byte = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_data_in.out_byte    = cur_byte;
            rsp_data_in.last_of_run = is_last;
            // advance within the job, restart at the next one
            idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder: one code unit in, zero to six UTF-8 bytes out.
// The output gives one byte per cycle while rsp_stall is low; a unit yields
// one byte below 0x80, two below 0x800, three for other single units, four
// for a surrogate pair (on its low half), and three more when a waiting high
// surrogate is flushed; a held high surrogate yields none. The front end
// takes a unit every cycle while the job queue (QUEUE_DEPTH jobs) has room,
// so the sustained rate is set by the byte serialiser.
`default_nettype none

module utf16_to_utf8_transcoder
   import u16u8_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    queue_full, push, pop, head_valid;
   job_type push_job, head_job;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
